/* sv/rgbhsv_pkg.sv */
// rgbhsv_pkg: widths and shared types of the rgb to hsv pixel converter
// no dependencies; imported by the interfaces and by every module of the block but rgbhsv_div
package rgbhsv_pkg;

   localparam int CHAN_W = 8;    // one color channel
   localparam int HUE_W  = 16;   // hue field, unsigned 0.16
   localparam int SAT_W  = 17;   // saturation field, unsigned 1.16
   localparam int HNUM_W = 11;   // hue numerator and divisor, up to 6*255

   // one classified pixel: dividends, divisors and brightness
   typedef struct packed {
      logic [HNUM_W-1:0] hnum;
      logic [HNUM_W-1:0] hden;
      logic [CHAN_W-1:0] snum;
      logic [CHAN_W-1:0] sden;
      logic [CHAN_W-1:0] bright;
   } cls_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    vld;
      cls_type cls;
   } head_type;

endpackage

/* sv/rgbhsv_if.sv */
// rgbhsv_req_if / rgbhsv_rsp_if: valid/ready channels of the converter
// depends on rgbhsv_pkg for the field widths
interface rgbhsv_req_if;
   import rgbhsv_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink (input valid, input red_in, input green_in, input blue_in,
                 output ready);
endinterface

interface rgbhsv_rsp_if;
   import rgbhsv_pkg::*;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue_out;
   logic [SAT_W-1:0]  saturation_out;
   logic [CHAN_W-1:0] brightness_out;

   modport source (output valid, output hue_out, output saturation_out,
                   output brightness_out, input ready);
   modport sink (input valid, input hue_out, input saturation_out,
                 input brightness_out, output ready);
endinterface

/* sv/rgb_to_hsv_pixel.sv */
// rgb_to_hsv_pixel: top level of the 8-bit rgb to hue/saturation/brightness converter
// depends on rgbhsv_pkg, rgbhsv_if, rgbhsv_front, rgbhsv_queue, rgbhsv_back
//
//   channel  dir  handshake        word
//   req_ch   in   valid / ready    red_in, green_in, blue_in (8 bits each)
//   rsp_ch   out  valid / ready    hue_out (0.16), saturation_out (1.16), brightness_out
//
// one word per clock sustained while rsp_ch is not stalled; a word passes the front register,
// the queue, then FRACTION_BITS + 1 divider stages before rsp_ch.valid rises
// the rate is set by the two divider pipelines, one quotient bit per stage
// reset clears the valid bits and the queue pointers only, no clearing pass
// a stalled rsp_ch freezes the divider pipelines; the queue then fills,
// and req_ch.ready drops once the front register is also occupied
module rgb_to_hsv_pixel #(
   parameter int FRACTION_BITS = 16,
   parameter int QUEUE_DEPTH   = 2
) (
   input  logic         clock,
   input  logic         reset,
   rgbhsv_req_if.sink   req_ch,
   rgbhsv_rsp_if.source rsp_ch
);
   import rgbhsv_pkg::*;

   // quotient width: one integer bit plus the fraction bits
   localparam int QW = FRACTION_BITS + 1;

   logic     cls_vld;
   cls_type  cls;
   logic     q_ready;
   logic     pop;
   head_type head;

   // front end: max/min, sector choice, dividend and divisor forming
   rgbhsv_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_ready (q_ready),
      .cls_vld (cls_vld),
      .cls     (cls)
   );

   // decouples the two halves so each can stall on its own
   rgbhsv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (cls_vld),
      .in_cls   (cls),
      .in_ready (q_ready),
      .pop      (pop),
      .head     (head)
   );

   // back end: both divisions in lockstep, output held in the last stage
   rgbhsv_back #(.QW(QW)) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   // a classified word waiting on a full queue must stay put
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (cls_vld && !q_ready) |=> cls_vld)
      else $error("front word lost while queue full");

endmodule

/* sv/rgbhsv_front.sv */
// rgbhsv_front: accepts a pixel, finds max/min and hue sector, forms the dividends
// depends on rgbhsv_pkg and rgbhsv_req_if
module rgbhsv_front (
   input  logic                clock,
   input  logic                reset,
   rgbhsv_req_if.sink          req_ch,
   input  logic                q_ready,
   output logic                cls_vld,
   output rgbhsv_pkg::cls_type cls
);
   import rgbhsv_pkg::*;

   logic [CHAN_W-1:0] r, g, b, mx, mn, delta;
   logic [HNUM_W-1:0] hoff, hnum, hden;
   logic              take;
   logic              vld_ff, vld_in;
   cls_type           cls_ff, cls_in;

   assign r = req_ch.red_in;
   assign g = req_ch.green_in;
   assign b = req_ch.blue_in;

   always_comb begin
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
   end

   assign delta = mx - mn;

   // sector priority red, green, blue; modular sum is exact since the result is >= 0
   always_comb begin
      if (mx == r) begin
         hoff = (g < b) ? HNUM_W'(delta) * HNUM_W'(6) : '0;
         hnum = hoff + HNUM_W'(g) - HNUM_W'(b);
      end else if (mx == g) begin
         hoff = HNUM_W'(delta) * HNUM_W'(2);
         hnum = hoff + HNUM_W'(b) - HNUM_W'(r);
      end else begin
         hoff = HNUM_W'(delta) * HNUM_W'(4);
         hnum = hoff + HNUM_W'(r) - HNUM_W'(g);
      end
      hden = HNUM_W'(delta) * HNUM_W'(6);
   end

   // grey and black pixels divide a zero hue by one; black also divides a zero saturation by one
   always_comb begin
      cls_in.hnum   = (delta == '0) ? '0 : hnum;
      cls_in.hden   = (delta == '0) ? HNUM_W'(1) : hden;
      cls_in.snum   = delta;
      cls_in.sden   = (mx == '0) ? CHAN_W'(1) : mx;
      cls_in.bright = mx;
   end

   assign req_ch.ready = !vld_ff || q_ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign vld_in       = take ? 1'b1 : (q_ready ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cls_ff <= cls_in;
      end
   end

   assign cls_vld = vld_ff;
   assign cls     = cls_ff;

endmodule

/* sv/rgbhsv_queue.sv */
// rgbhsv_queue: short fifo of classified pixels between front and back end
// depends on rgbhsv_pkg
module rgbhsv_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  rgbhsv_pkg::cls_type  in_cls,
   output logic                 in_ready,
   input  logic                 pop,
   output rgbhsv_pkg::head_type head
);
   import rgbhsv_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cls_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;

   assign in_ready = (count_ff != CW'(DEPTH));
   assign push     = in_vld && in_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_cls;
      end
   end

   assign head.vld = (count_ff != '0);
   assign head.cls = mem_ff[rd_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(count_ff))
      else $error("queue count moved without push or pop");

endmodule

/* sv/rgbhsv_div.sv */
// rgbhsv_div: pipelined restoring divider, one quotient bit per stage
// no package dependency; dividend must stay below twice the divisor
module rgbhsv_div #(
   parameter int DW = 11,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] rem_in [QW];
   logic [DW-1:0] den_ff [QW];
   logic [DW-1:0] den_in [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [QW-1:0] quo_in [QW];
   logic [DW:0]   dbl    [QW];
   logic          ge     [QW];

   always_comb begin
      // integer bit
      dbl[0]    = {1'b0, num};
      ge[0]     = (num >= den);
      rem_in[0] = ge[0] ? num - den : num;
      den_in[0] = den;
      quo_in[0] = QW'(ge[0]);
      // fraction bits, each stage reads only the stage before
      for (int s = 1; s < QW; s++) begin
         dbl[s]    = {rem_ff[s-1], 1'b0};
         ge[s]     = (dbl[s] >= {1'b0, den_ff[s-1]});
         rem_in[s] = ge[s] ? DW'(dbl[s] - {1'b0, den_ff[s-1]}) : dbl[s][DW-1:0];
         den_in[s] = den_ff[s-1];
         quo_in[s] = {quo_ff[s-1][QW-2:0], ge[s]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QW; s++) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

/* sv/rgbhsv_back.sv */
// rgbhsv_back: hue and saturation divider pipelines with the output stage
// depends on rgbhsv_pkg, rgbhsv_rsp_if and rgbhsv_div
module rgbhsv_back #(
   parameter int QW = 17
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbhsv_pkg::head_type head,
   output logic                 pop,
   rgbhsv_rsp_if.source         rsp_ch
);
   import rgbhsv_pkg::*;

   logic              en;
   logic              vld_ff [QW];
   logic [CHAN_W-1:0] bri_ff [QW];
   logic [QW-1:0]     hue_q, sat_q;
   logic [63:0]       hue_wide, sat_wide;

   // whole pipeline advances unless a finished word is held
   assign en  = !vld_ff[QW-1] || rsp_ch.ready;
   assign pop = en && head.vld;

   rgbhsv_div #(.DW(HNUM_W), .QW(QW)) u_hue_div (
      .clock (clock),
      .en    (en),
      .num   (head.cls.hnum),
      .den   (head.cls.hden),
      .quo   (hue_q)
   );

   rgbhsv_div #(.DW(CHAN_W), .QW(QW)) u_sat_div (
      .clock (clock),
      .en    (en),
      .num   (head.cls.snum),
      .den   (head.cls.sden),
      .quo   (sat_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QW; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= head.vld;
         for (int s = 1; s < QW; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bri_ff[0] <= head.cls.bright;
         for (int s = 1; s < QW; s++) bri_ff[s] <= bri_ff[s-1];
      end
   end

   // fit the quotients to the field widths
   assign hue_wide = 64'(hue_q);
   assign sat_wide = 64'(sat_q);

   assign rsp_ch.valid          = vld_ff[QW-1];
   assign rsp_ch.hue_out        = hue_wide[HUE_W-1:0];
   assign rsp_ch.saturation_out = sat_wide[SAT_W-1:0];
   assign rsp_ch.brightness_out = bri_ff[QW-1];

   a_shift: assert property (@(posedge clock) disable iff (reset)
      en |=> vld_ff[QW-1] == $past(vld_ff[QW-2]))
      else $error("valid did not shift into the output stage");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> vld_ff[QW-1] == $past(vld_ff[QW-1]))
      else $error("output stage changed while frozen");

endmodule
